// File: hw/rtl/srts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types and constants for the signed radix to symbols converter.
// ----------------------------------------------------------------------------
package srts_pkg;

  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_SYMS   = 16;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned DIV_STEPS  = 8;

  localparam logic [SYM_W-1:0]   CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0]   CHAR_TOP   = 8'd126;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;

  typedef enum logic [1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [RADIX_W-1:0]        radix;
    logic [NUM_SYMS*SYM_W-1:0] symbols;
  } cfg_t;

endpackage

// File: hw/rtl/srts_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srts_regs
// APB register file: radix and the two alphabet words.
// ----------------------------------------------------------------------------
module srts_regs
  import srts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [DATA_W-1:0]  alpha_lo_q, alpha_lo_d;
  logic [DATA_W-1:0]  alpha_hi_q, alpha_hi_d;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:3]);

  always_comb begin
    radix_d    = radix_q;
    alpha_lo_d = alpha_lo_q;
    alpha_hi_d = alpha_hi_q;
    prdata     = '0;
    unique case (idx)
      REG_RADIX: begin
        prdata = DATA_W'(radix_q);
        if (wr_en) radix_d = pwdata[RADIX_W-1:0];
      end
      REG_ALPHA_LO: begin
        prdata = alpha_lo_q;
        if (wr_en) alpha_lo_d = pwdata;
      end
      REG_ALPHA_HI: begin
        prdata = alpha_hi_q;
        if (wr_en) alpha_hi_d = pwdata;
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= '0;
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
    end else begin
      radix_q    <= radix_d;
      alpha_lo_q <= alpha_lo_d;
      alpha_hi_q <= alpha_hi_d;
    end
  end

  assign cfg_o.radix   = radix_q;
  assign cfg_o.symbols = {alpha_hi_q, alpha_lo_q};

endmodule

// File: hw/rtl/srts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srts_front
// Input side: checks the alphabet, splits sign and magnitude, queues work.
// ----------------------------------------------------------------------------
module srts_front
  import srts_pkg::*;
#(
  parameter int unsigned MAX_RADIX   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cfg_t                          cfg_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [VALUE_WIDTH:0]          push_data_o
);

  logic                   ok;
  logic [SYM_W-1:0]       ci;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;

  always_comb begin
    ok = (cfg_i.radix >= RADIX_MIN) && (cfg_i.radix <= RADIX_W'(MAX_RADIX));
    ci = '0;
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < cfg_i.radix) begin
        ci = cfg_i.symbols[i*SYM_W +: SYM_W];
        if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE || ci > CHAR_TOP) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < cfg_i.radix && cfg_i.symbols[j*SYM_W +: SYM_W] == ci) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign v   = value_i;
  assign neg = v[VALUE_WIDTH-1];
  assign mag = neg ? (~v + 1'b1) : v;

  // invalid alphabet: beat is taken and dropped
  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i && ok;
  assign push_data_o = {neg, mag};

endmodule

// File: hw/rtl/srts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srts_fifo
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module srts_fifo #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/srts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srts_back
// Output side: digit extraction by long division, digit store, symbol emit.
// ----------------------------------------------------------------------------
module srts_back
  import srts_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 empty_i,
  input  logic [VALUE_WIDTH:0] pop_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SYM_W-1:0]     symbol_o,
  output logic                 last_o
);

  localparam int unsigned PASSES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIV_W  = PASSES * DIV_STEPS;
  localparam int unsigned PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int unsigned IDX_W  = $clog2(VALUE_WIDTH);
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [DIV_W-1:0]   div_q, div_d, div_next;
  logic [RADIX_W-1:0] rem_q, rem_d, rem_next;
  logic [PASS_W-1:0]  pass_q, pass_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               neg_q, neg_d;
  logic [DIGIT_W-1:0] mem_q [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               mem_we;
  logic               out_valid_q, out_valid_d;
  logic [SYM_W-1:0]   symbol_q, symbol_d;
  logic               last_q, last_d;
  logic               out_free;

  // DIV_STEPS bits of restoring division per cycle; div_q shifts quotient in
  always_comb begin
    rem_next = rem_q;
    div_next = div_q;
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_next = {rem_next[RADIX_W-2:0], div_next[DIV_W-1]};
      div_next = {div_next[DIV_W-2:0], 1'b0};
      if (rem_next >= cfg_i.radix) begin
        rem_next    = rem_next - cfg_i.radix;
        div_next[0] = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    mem_we      = 1'b0;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          div_d   = DIV_W'(pop_data_i[VALUE_WIDTH-1:0]);
          neg_d   = pop_data_i[VALUE_WIDTH];
          rem_d   = '0;
          pass_d  = '0;
          idx_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_d  = div_next;
        rem_d  = rem_next;
        pass_d = pass_q + 1'b1;
        if (pass_q == LAST_PASS) begin
          mem_we = 1'b1;
          pass_d = '0;
          rem_d  = '0;
          if (div_next == '0) state_d = ST_READ;
          else idx_d = idx_q + 1'b1;
        end
      end
      ST_READ: state_d = neg_q ? ST_SIGN : ST_EMIT;
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = cfg_i.symbols[{rd_data_q, 3'b000} +: SYM_W];
          last_d      = (idx_q == '0);
          if (idx_q == '0) state_d = ST_IDLE;
          else idx_d = idx_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q] <= rem_next[DIGIT_W-1:0];
    rd_data_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i) begin
    div_q    <= div_d;
    rem_q    <= rem_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  a_sign_needs_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> neg_q)
    else $error("sign state without negative value");

  a_read_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(state_q == ST_DIV))
    else $error("digit read not preceded by division");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (pass_q <= LAST_PASS))
    else $error("division pass counter out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && symbol_q == CHAR_MINUS) |-> !last_q)
    else $error("minus sign flagged as final beat");

endmodule

// File: hw/rtl/signed_radix_to_symbols_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_to_symbols_core
// Renders signed values as text in a programmable radix and alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Program radix (0x00), alphabet_low (0x08) and alphabet_high (0x10) over
//   APB while idle. Each input beat on value_i yields a '-' for negative
//   values and then one beat per digit, most significant first; last_o
//   marks the final beat. With an invalid alphabet the beat is consumed and
//   nothing is emitted.
//   The back end handles one value at a time; a two-entry queue lets the
//   input side take beats meanwhile. Once a value is popped from the queue, each
//   digit takes a full long division of it (8 quotient bits per cycle) and goes
//   into the digit store, which is then read back to emit the output beats.
//   Reset clears the registers to zero (alphabet invalid) and empties the
//   queue. out_stall_i holds the output beat and pauses emission; the queue
//   then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module signed_radix_to_symbols_core
  import srts_pkg::*;
#(
  parameter int unsigned MAX_RADIX   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SYM_W-1:0]              symbol_o,
  output logic                          last_o
);

  cfg_t                 cfg;
  logic                 push, pop, full, empty;
  logic [VALUE_WIDTH:0] push_data, pop_data;

  srts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srts_front #(
    .MAX_RADIX   (MAX_RADIX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_i       (cfg),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  srts_fifo #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  srts_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

endmodule
